[rtl/core/preemptive_remaining_time_scheduler_unit_defines.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef PREEMPTIVE_REMAINING_TIME_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_REMAINING_TIME_SCHEDULER_UNIT_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define PRTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true.
`define PRTS_ASSERT_NEVER(name, expr, msg) \
  `PRTS_ASSERT(name, !(expr), msg)

`endif

[rtl/core/prts_pkg.sv]
// Shared types and constants for the preemptive remaining-time scheduler.
package prts_pkg;

  localparam int unsigned MaxProcessesDef = 16;
  localparam int unsigned TimeWidthDef    = 16;

  localparam int unsigned CmdW       = 2;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned FieldTimeW = 16;
  localparam int unsigned PrioW      = 8;
  localparam int unsigned ModeW      = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [ModeW-1:0] {
    MODE_SRTF = 2'd0,
    MODE_LRTF = 2'd1,
    MODE_PRIO = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_CALC,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic load_en;
    logic clear_en;
    logic tick_start;
    logic rd_en;
    logic cmp_en;
    logic calc_en;
    logic update_en;
  } prts_cmd_t;

  typedef struct packed {
    logic out_ready;
  } prts_status_t;

endpackage

[rtl/core/prts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module prts_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/prts_ctrl.sv]
// Scheduler controller: accepts beats and sequences the slot scan and update.
`include "preemptive_remaining_time_scheduler_unit_defines.svh"

module prts_ctrl import prts_pkg::*; #(
  parameter int unsigned MaxProcesses = MaxProcessesDef,
  localparam int unsigned IdxW = $clog2(MaxProcesses)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [CmdW-1:0]     command_i,
  output logic                in_stall_o,
  input  prts_status_t        status_i,
  output prts_cmd_t           cmd_o,
  output logic [IdxW-1:0]     rd_idx_o,
  output logic [IdxW-1:0]     cmp_idx_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxProcesses - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            cmp_q, cmp_d;
  logic [IdxW-1:0] cmp_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cmp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cmp_q   <= cmp_d;
    end
  end

  // Slot whose read data arrives next cycle.
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        idx_d      = '0;
        if (in_valid_i) begin
          case (command_i)
            CMD_LOAD:  cmd_o.load_en = 1'b1;
            CMD_CLEAR: cmd_o.clear_en = 1'b1;
            CMD_TICK: begin
              cmd_o.tick_start = 1'b1;
              state_d          = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        idx_d       = idx_q + IdxW'(1);
        if (idx_q == LastIdx) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_CALC;
      ST_CALC: begin
        cmd_o.calc_en = 1'b1;
        state_d       = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold until the output register has room
        if (status_i.out_ready) begin
          cmd_o.update_en = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.cmp_en = cmp_q;
  end

  assign cmp_d     = (state_q == ST_SCAN);
  assign rd_idx_o  = idx_q;
  assign cmp_idx_o = cmp_idx_q;

  `PRTS_ASSERT(a_last_follows_scan, state_q == ST_LAST |-> $past(state_q) == ST_SCAN, "last compare without scan")
  `PRTS_ASSERT(a_scan_from_zero, (state_q == ST_SCAN && $past(state_q) == ST_IDLE) |-> idx_q == '0, "scan does not start at slot zero")
  `PRTS_ASSERT_NEVER(a_accept_during_scan, !in_stall_o && (cmd_o.cmp_en || cmd_o.rd_en), "beat accepted while scan busy")

endmodule

[rtl/core/prts_datapath.sv]
// Scheduler datapath: slot tables, live bits, time counter, winner search, result register.
`include "preemptive_remaining_time_scheduler_unit_defines.svh"

module prts_datapath import prts_pkg::*; #(
  parameter int unsigned MaxProcesses = MaxProcessesDef,
  parameter int unsigned TimeWidth    = TimeWidthDef,
  localparam int unsigned IdxW = $clog2(MaxProcesses)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sched_mode_we_i,
  input  logic [ModeW-1:0]      sched_mode_i,
  input  logic [SlotW-1:0]      slot_i,
  input  logic [FieldTimeW-1:0] arrival_i,
  input  logic [FieldTimeW-1:0] burst_i,
  input  logic [PrioW-1:0]      prio_i,
  input  prts_cmd_t             cmd_i,
  input  logic [IdxW-1:0]       rd_idx_i,
  input  logic [IdxW-1:0]       cmp_idx_i,
  output prts_status_t          status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SlotW-1:0]      run_slot_o,
  output logic                  idle_o,
  output logic                  finished_o,
  output logic [FieldTimeW-1:0] now_time_o,
  output logic [FieldTimeW-1:0] turnaround_o,
  output logic [FieldTimeW-1:0] waiting_o,
  output logic                  all_done_o
);

  localparam int unsigned TW    = TimeWidth;
  localparam int unsigned ExtW  = (TW > FieldTimeW) ? TW : FieldTimeW;
  localparam int unsigned AttrW = 2 * TW + PrioW;
  localparam logic [TW-1:0] TimeMax = '1;

  function automatic logic [TW-1:0] sat_time(input logic [FieldTimeW-1:0] v);
    logic [ExtW-1:0] ext;
    ext = ExtW'(v);
    if (ext > ExtW'(TimeMax)) begin
      return TimeMax;
    end
    return TW'(ext);
  endfunction

  logic [ModeW-1:0]        mode_q;
  logic [TW-1:0]           time_q;
  logic [MaxProcesses-1:0] live_q;
  logic                    have_q;
  logic                    done_q;
  logic [IdxW-1:0]         best_idx_q;
  logic [TW-1:0]           best_rem_q;
  logic [TW-1:0]           best_arr_q;
  logic [TW-1:0]           best_bur_q;
  logic [PrioW-1:0]        best_prio_q;
  logic [TW-1:0]           tat_q;

  logic                    out_valid_q;
  logic [SlotW-1:0]        out_run_slot_q;
  logic                    out_idle_q;
  logic                    out_finished_q;
  logic [FieldTimeW-1:0]   out_now_time_q;
  logic [FieldTimeW-1:0]   out_turnaround_q;
  logic [FieldTimeW-1:0]   out_waiting_q;
  logic                    out_all_done_q;

  logic [TW-1:0]           load_arr;
  logic [TW-1:0]           load_bur;
  logic                    slot_ok;
  logic [IdxW-1:0]         load_idx;
  logic                    load_we;

  logic [AttrW-1:0]        attr_rd;
  logic [TW-1:0]           rd_arr;
  logic [TW-1:0]           rd_bur;
  logic [PrioW-1:0]        rd_prio;
  logic [TW-1:0]           rd_rem;

  logic                    rem_we;
  logic [IdxW-1:0]         rem_waddr;
  logic [TW-1:0]           rem_wdata;
  logic                    rem_upd_we;
  logic [TW-1:0]           rem_dec;
  logic                    fin;

  logic                    eligible;
  logic                    beats;
  logic                    take;
  logic [TW-1:0]           time_next;
  logic [TW-1:0]           wait_val;
  logic [MaxProcesses-1:0] fin_mask;
  logic                    ran;

  assign load_arr = sat_time(arrival_i);
  assign load_bur = sat_time(burst_i);
  assign slot_ok  = 32'(slot_i) < MaxProcesses;
  assign load_idx = IdxW'(slot_i);
  assign load_we  = cmd_i.load_en && slot_ok;

  prts_ram #(
    .Width(AttrW),
    .Depth(MaxProcesses)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (load_idx),
    .wdata_i ({load_arr, load_bur, prio_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx_i),
    .rdata_o (attr_rd)
  );

  assign rd_arr  = attr_rd[AttrW-1 -: TW];
  assign rd_bur  = attr_rd[PrioW +: TW];
  assign rd_prio = attr_rd[PrioW-1:0];

  assign ran        = have_q && !done_q;
  assign rem_upd_we = cmd_i.update_en && ran;
  assign rem_dec    = best_rem_q - TW'(1);
  assign fin        = (best_rem_q == TW'(1));
  assign rem_we     = load_we || rem_upd_we;
  assign rem_waddr  = load_we ? load_idx : best_idx_q;
  assign rem_wdata  = load_we ? load_bur : rem_dec;

  prts_ram #(
    .Width(TW),
    .Depth(MaxProcesses)
  ) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx_i),
    .rdata_o (rd_rem)
  );

  // Candidate against current best; strict so the lower slot keeps a tie.
  always_comb begin
    if (mode_q == MODE_PRIO) begin
      beats = rd_prio < best_prio_q;
    end else if (rd_rem != best_rem_q) begin
      beats = (mode_q == MODE_LRTF) ? (rd_rem > best_rem_q) : (rd_rem < best_rem_q);
    end else begin
      beats = rd_arr < best_arr_q;
    end
  end

  assign eligible  = live_q[cmp_idx_i] && (rd_arr <= time_q);
  assign take      = cmd_i.cmp_en && eligible && (!have_q || beats);
  assign time_next = (time_q == TimeMax) ? time_q : time_q + TW'(1);
  assign wait_val  = (tat_q >= best_bur_q) ? tat_q - best_bur_q : '0;

  always_comb begin
    fin_mask = '0;
    if (ran && fin) begin
      fin_mask[best_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SRTF;
      time_q <= '0;
      live_q <= '0;
      have_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (sched_mode_we_i) begin
        mode_q <= sched_mode_i;
      end
      if (cmd_i.clear_en) begin
        time_q <= '0;
        live_q <= '0;
      end else if (load_we) begin
        live_q[load_idx] <= (load_bur != '0);
      end else if (cmd_i.update_en) begin
        if (!done_q) begin
          time_q <= time_next;
        end
        live_q <= live_q & ~fin_mask;
      end
      if (cmd_i.tick_start) begin
        have_q <= 1'b0;
        done_q <= ~|live_q;
      end else if (take) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q  <= cmp_idx_i;
      best_rem_q  <= rd_rem;
      best_arr_q  <= rd_arr;
      best_bur_q  <= rd_bur;
      best_prio_q <= rd_prio;
    end
    if (cmd_i.calc_en) begin
      tat_q <= (time_next >= best_arr_q) ? time_next - best_arr_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update_en) begin
      out_run_slot_q   <= ran ? SlotW'(best_idx_q) : '0;
      out_idle_q       <= !done_q && !have_q;
      out_finished_q   <= ran && fin;
      out_now_time_q   <= FieldTimeW'(done_q ? time_q : time_next);
      out_turnaround_q <= (ran && fin) ? FieldTimeW'(tat_q) : '0;
      out_waiting_q    <= (ran && fin) ? FieldTimeW'(wait_val) : '0;
      out_all_done_q   <= done_q || ~|(live_q & ~fin_mask);
    end
  end

  assign status_o.out_ready = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign run_slot_o   = out_run_slot_q;
  assign idle_o       = out_idle_q;
  assign finished_o   = out_finished_q;
  assign now_time_o   = out_now_time_q;
  assign turnaround_o = out_turnaround_q;
  assign waiting_o    = out_waiting_q;
  assign all_done_o   = out_all_done_q;

  `PRTS_ASSERT(a_winner_is_live, (cmd_i.update_en && ran) |-> live_q[best_idx_q], "selected slot is not live")
  `PRTS_ASSERT_NEVER(a_idle_excl, out_valid_q && out_idle_q && (out_finished_q || out_all_done_q), "idle beat reports finish or all done")

endmodule

[rtl/core/preemptive_remaining_time_scheduler_unit.sv]
// Top level of the preemptive remaining-time / priority scheduler.
// A load, clear or unknown command beat is taken while idle and returns
// no result. A tick beat holds off the next beat until it is through:
// the beat is accepted, there is one RAM read per slot through a single
// comparator, the last compare completes, the turnaround is subtracted,
// and the update step writes the winner, the time counter and the result
// register. The result register lets the next beat be accepted while a
// tick result is still stalled; a later tick waits in its update step
// until that result is taken. Slot tables need no clearing pass after
// reset: per-slot live bits hold which slots have time left.
`include "preemptive_remaining_time_scheduler_unit_defines.svh"

module preemptive_remaining_time_scheduler_unit import prts_pkg::*; #(
  parameter int unsigned MaxProcesses = MaxProcessesDef,
  parameter int unsigned TimeWidth    = TimeWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sched_mode_we_i,
  input  logic [ModeW-1:0]      sched_mode_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CmdW-1:0]       command_i,
  input  logic [SlotW-1:0]      slot_i,
  input  logic [FieldTimeW-1:0] arrival_i,
  input  logic [FieldTimeW-1:0] burst_i,
  input  logic [PrioW-1:0]      prio_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SlotW-1:0]      run_slot_o,
  output logic                  idle_o,
  output logic                  finished_o,
  output logic [FieldTimeW-1:0] now_time_o,
  output logic [FieldTimeW-1:0] turnaround_o,
  output logic [FieldTimeW-1:0] waiting_o,
  output logic                  all_done_o
);

  localparam int unsigned IdxW = $clog2(MaxProcesses);

  prts_cmd_t       cmd;
  prts_status_t    status;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] cmp_idx;

  prts_ctrl #(
    .MaxProcesses(MaxProcesses)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .rd_idx_o   (rd_idx),
    .cmp_idx_o  (cmp_idx)
  );

  prts_datapath #(
    .MaxProcesses(MaxProcesses),
    .TimeWidth   (TimeWidth)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sched_mode_we_i (sched_mode_we_i),
    .sched_mode_i    (sched_mode_i),
    .slot_i          (slot_i),
    .arrival_i       (arrival_i),
    .burst_i         (burst_i),
    .prio_i          (prio_i),
    .cmd_i           (cmd),
    .rd_idx_i        (rd_idx),
    .cmp_idx_i       (cmp_idx),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .run_slot_o      (run_slot_o),
    .idle_o          (idle_o),
    .finished_o      (finished_o),
    .now_time_o      (now_time_o),
    .turnaround_o    (turnaround_o),
    .waiting_o       (waiting_o),
    .all_done_o      (all_done_o)
  );

endmodule
